// File: rtl/rect_obstacle_collision_table_assert.svh
// ----------------------------------------------------------------------------
// rect_obstacle_collision_table_assert.svh
// Assertion macros for the obstacle collision table. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RECT_OBSTACLE_COLLISION_TABLE_ASSERT_SVH
`define RECT_OBSTACLE_COLLISION_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define ROCT_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("%m: check failed");
`define ROCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define ROCT_ASSERT(lbl, expr)
`define ROCT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/roct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roct_pkg
// Types and constants shared by the obstacle collision table.
// ----------------------------------------------------------------------------
package roct_pkg;

    localparam int MAX_RECTS     = 64;
    localparam int COORD_BITS    = 16;
    localparam int SIZE_BITS     = 12;
    localparam int IDX_BITS      = $clog2(MAX_RECTS);
    localparam int CNT_BITS      = $clog2(MAX_RECTS + 1);
    localparam int POS_W         = 2 * COORD_BITS;
    localparam int SIZE_W        = 2 * SIZE_BITS;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_IDX_BITS  = CFG_ADDR_BITS - 2;
    localparam int APB_DATA_W    = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_PLAYER_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLAYER_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_MOVE   = 3'd2,
        ACT_BOX    = 3'd3,
        ACT_POINT  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

endpackage

// File: rtl/roct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roct_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module roct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/rect_obstacle_collision_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_obstacle_collision_table
// Ordered table of axis-aligned obstacle rectangles with collision queries.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one action per transaction: append, remove, move, box query
//   or point query. m_* returns one result per transaction: hit, status and
//   the entry count after the action. The APB port sets the player box size.
//   One action is in flight at a time; s_ready is high while the block is
//   idle, even if the previous result still waits in the output register.
//   Append, move, unused codes and rejected actions go from EXEC to FINISH.
//   Remove: entries above the index are shifted down one per cycle through
//   the table RAM, then the entry count drops by one.
//   Queries: every valid entry is read once through the RAM read port.
//   s_ready rises in the same cycle as a result enters the output register.
//   Reset empties the table (count to zero, no clearing pass) and clears the
//   player size. When m_ready is low, a finished result waits in the control
//   logic until the output register frees up.
// ----------------------------------------------------------------------------
`include "rect_obstacle_collision_table_assert.svh"

module rect_obstacle_collision_table (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_action,
    input  logic [roct_pkg::IDX_BITS-1:0]         s_entry_index,
    input  logic signed [roct_pkg::COORD_BITS-1:0] s_pos_x,
    input  logic signed [roct_pkg::COORD_BITS-1:0] s_pos_y,
    input  logic [roct_pkg::SIZE_BITS-1:0]        s_rect_w,
    input  logic [roct_pkg::SIZE_BITS-1:0]        s_rect_h,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [1:0]                            m_status,
    output logic [roct_pkg::CNT_BITS-1:0]         m_entry_count,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [roct_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [roct_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [roct_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    localparam int CW = roct_pkg::COORD_BITS;
    localparam int SW = roct_pkg::SIZE_BITS;
    localparam int IW = roct_pkg::IDX_BITS;
    localparam int NW = roct_pkg::CNT_BITS;
    localparam int EW = CW + 1;

    // configuration
    logic [SW-1:0]                     player_w_reg;
    logic [SW-1:0]                     player_h_reg;
    logic [roct_pkg::CFG_IDX_BITS-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[roct_pkg::CFG_ADDR_BITS-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            player_w_reg <= '0;
            player_h_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (cfg_idx)
                roct_pkg::REG_PLAYER_WIDTH:  player_w_reg <= pwdata[SW-1:0];
                roct_pkg::REG_PLAYER_HEIGHT: player_h_reg <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            roct_pkg::REG_PLAYER_WIDTH:
                prdata = {{(roct_pkg::APB_DATA_W-SW){1'b0}}, player_w_reg};
            roct_pkg::REG_PLAYER_HEIGHT:
                prdata = {{(roct_pkg::APB_DATA_W-SW){1'b0}}, player_h_reg};
            default: prdata = '0;
        endcase
    end

    // control and item registers
    roct_pkg::state_t         state_reg, state_next;
    logic [NW-1:0]            count_reg, count_next;
    logic [NW-1:0]            rd_ptr_reg, rd_ptr_next;
    logic                     pend_reg, pend_next;
    logic [IW-1:0]            shift_wa_reg, shift_wa_next;
    logic                     hit_reg, hit_next;
    logic [1:0]               status_reg, status_next;
    logic [2:0]               act_reg;
    logic [IW-1:0]            idx_reg;
    logic signed [CW-1:0]     px_reg, py_reg;
    logic [SW-1:0]            rw_reg, rh_reg;
    logic                     m_valid_reg;
    logic                     m_hit_reg;
    logic [1:0]               m_status_reg;
    logic [NW-1:0]            m_count_reg;
    logic                     s_fire;
    logic                     rd_en;
    logic                     idx_bad;

    // table RAMs
    logic                     pos_we, size_we;
    logic [IW-1:0]            wr_addr;
    logic [roct_pkg::POS_W-1:0]  pos_wdata, pos_rdata;
    logic [roct_pkg::SIZE_W-1:0] size_wdata, size_rdata;

    // overlap test on the entry read last cycle
    logic signed [EW-1:0]     ax_lo, ax_hi, ay_lo, ay_hi;
    logic signed [EW-1:0]     bx_lo, bx_hi, by_lo, by_hi;
    logic [SW-1:0]            qw, qh;
    logic                     entry_hit;

    assign s_ready = (state_reg == roct_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign rd_en   = (rd_ptr_reg < count_reg);
    assign idx_bad = (NW'(idx_reg) >= count_reg);

    always_comb begin
        qw = (act_reg == roct_pkg::ACT_BOX) ? player_w_reg : '0;
        qh = (act_reg == roct_pkg::ACT_BOX) ? player_h_reg : '0;
        ax_lo = {px_reg[CW-1], px_reg};
        ay_lo = {py_reg[CW-1], py_reg};
        ax_hi = ax_lo + $signed({{(EW-SW){1'b0}}, qw});
        ay_hi = ay_lo + $signed({{(EW-SW){1'b0}}, qh});
        bx_lo = {pos_rdata[CW-1], pos_rdata[CW-1:0]};
        by_lo = {pos_rdata[2*CW-1], pos_rdata[2*CW-1:CW]};
        bx_hi = bx_lo + $signed({{(EW-SW){1'b0}}, size_rdata[SW-1:0]});
        by_hi = by_lo + $signed({{(EW-SW){1'b0}}, size_rdata[2*SW-1:SW]});
        entry_hit = (ax_lo <= bx_hi) && (bx_lo <= ax_hi) &&
                    (ay_lo <= by_hi) && (by_lo <= ay_hi);
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        pend_next     = pend_reg;
        shift_wa_next = shift_wa_reg;
        hit_next      = hit_reg;
        status_next   = status_reg;
        pos_we        = 1'b0;
        size_we       = 1'b0;
        wr_addr       = count_reg[IW-1:0];
        pos_wdata     = {py_reg, px_reg};
        size_wdata    = {rh_reg, rw_reg};

        case (state_reg)
            roct_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = roct_pkg::ST_EXEC;
                end
            end
            roct_pkg::ST_EXEC: begin
                hit_next    = 1'b0;
                status_next = roct_pkg::STS_OK;
                pend_next   = 1'b0;
                state_next  = roct_pkg::ST_FINISH;
                case (act_reg)
                    roct_pkg::ACT_APPEND: begin
                        if (count_reg >= NW'(roct_pkg::MAX_RECTS)) begin
                            status_next = roct_pkg::STS_FULL;
                        end else begin
                            pos_we     = 1'b1;
                            size_we    = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    roct_pkg::ACT_REMOVE: begin
                        if (idx_bad) begin
                            status_next = roct_pkg::STS_RANGE;
                        end else begin
                            rd_ptr_next = NW'(idx_reg) + 1'b1;
                            state_next  = roct_pkg::ST_SHIFT;
                        end
                    end
                    roct_pkg::ACT_MOVE: begin
                        if (idx_bad) begin
                            status_next = roct_pkg::STS_RANGE;
                        end else begin
                            pos_we  = 1'b1;
                            wr_addr = idx_reg;
                        end
                    end
                    roct_pkg::ACT_BOX, roct_pkg::ACT_POINT: begin
                        rd_ptr_next = '0;
                        state_next  = roct_pkg::ST_SCAN;
                    end
                    default: ;
                endcase
            end
            roct_pkg::ST_SHIFT: begin
                // read entry i+2 while entry i gets entry i+1, the data read last cycle
                pos_we        = pend_reg;
                size_we       = pend_reg;
                wr_addr       = shift_wa_reg;
                pos_wdata     = pos_rdata;
                size_wdata    = size_rdata;
                pend_next     = rd_en;
                shift_wa_next = IW'(rd_ptr_reg - 1'b1);
                if (rd_en) begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (!rd_en && !pend_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = roct_pkg::ST_FINISH;
                end
            end
            roct_pkg::ST_SCAN: begin
                pend_next = rd_en;
                if (rd_en) begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (pend_reg && entry_hit) begin
                    hit_next = 1'b1;
                end
                if (!rd_en && !pend_reg) begin
                    state_next = roct_pkg::ST_FINISH;
                end
            end
            roct_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = roct_pkg::ST_IDLE;
                end
            end
            default: state_next = roct_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= roct_pkg::ST_IDLE;
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            status_reg <= roct_pkg::STS_OK;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            pend_reg   <= pend_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_wa_reg <= shift_wa_next;
        if (s_fire) begin
            act_reg <= s_action;
            idx_reg <= s_entry_index;
            px_reg  <= s_pos_x;
            py_reg  <= s_pos_y;
            rw_reg  <= s_rect_w;
            rh_reg  <= s_rect_h;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == roct_pkg::ST_FINISH && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == roct_pkg::ST_FINISH && (!m_valid_reg || m_ready)) begin
            m_hit_reg    <= hit_reg;
            m_status_reg <= status_reg;
            m_count_reg  <= count_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

    roct_ram #(
        .WIDTH (roct_pkg::POS_W),
        .DEPTH (roct_pkg::MAX_RECTS)
    ) u_pos_ram (
        .clk   (aclk),
        .we    (pos_we),
        .waddr (wr_addr),
        .wdata (pos_wdata),
        .raddr (rd_ptr_reg[IW-1:0]),
        .rdata (pos_rdata)
    );

    roct_ram #(
        .WIDTH (roct_pkg::SIZE_W),
        .DEPTH (roct_pkg::MAX_RECTS)
    ) u_size_ram (
        .clk   (aclk),
        .we    (size_we),
        .waddr (wr_addr),
        .wdata (size_wdata),
        .raddr (rd_ptr_reg[IW-1:0]),
        .rdata (size_rdata)
    );

    `ROCT_ASSERT(a_count_max, count_reg <= NW'(roct_pkg::MAX_RECTS))
    `ROCT_ASSERT(a_scan_no_write, (state_reg == roct_pkg::ST_SCAN) |-> (!pos_we && !size_we))
    `ROCT_ASSERT_NEXT(a_scan_keeps_count, state_reg == roct_pkg::ST_SCAN, $stable(count_reg))
    `ROCT_ASSERT(a_shift_in_table,
        (state_reg == roct_pkg::ST_SHIFT && pend_reg) |-> (NW'(shift_wa_reg) < count_reg))
    `ROCT_ASSERT_NEXT(a_result_from_finish, !m_valid_reg || m_ready,
        !m_valid_reg || $past(state_reg) == roct_pkg::ST_FINISH)

endmodule

// File: verif/rect_obstacle_collision_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_obstacle_collision_table_tb
// Self-checking bench for the obstacle table: appends, removes, moves and
// box and point collision queries are driven over the valid/ready input
// channel. A scoreboard keeps a shadow copy of the table and the player box
// size, and checks every result (hit, status, entry count) in order. Both
// channels idle and stall at random, and the player box size is reprogrammed
// over APB between phases while the block is drained.
// ----------------------------------------------------------------------------
module rect_obstacle_collision_table_tb;

    localparam int ACTION_SPACE    = 1 << 3;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 340;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        logic [2:0]                             action;
        logic [roct_pkg::IDX_BITS-1:0]          index;
        logic signed [roct_pkg::COORD_BITS-1:0] x;
        logic signed [roct_pkg::COORD_BITS-1:0] y;
        logic [roct_pkg::SIZE_BITS-1:0]         w;
        logic [roct_pkg::SIZE_BITS-1:0]         h;
    } obstacle_txn_t;

    typedef struct {
        logic                          hit;
        logic [1:0]                    status;
        logic [roct_pkg::CNT_BITS-1:0] count;
    } collision_result_t;

    class collision_scoreboard;
        int rx[roct_pkg::MAX_RECTS];
        int ry[roct_pkg::MAX_RECTS];
        int rw[roct_pkg::MAX_RECTS];
        int rh[roct_pkg::MAX_RECTS];
        int n_rects;
        int box_w;
        int box_h;
        int errors;
        int checked;
        collision_result_t expected_q[$];

        function void set_player(logic [roct_pkg::CFG_IDX_BITS-1:0] reg_idx,
                                 logic [roct_pkg::APB_DATA_W-1:0] val);
            if (reg_idx == roct_pkg::REG_PLAYER_WIDTH) begin
                box_w = int'(val[roct_pkg::SIZE_BITS-1:0]);
            end else if (reg_idx == roct_pkg::REG_PLAYER_HEIGHT) begin
                box_h = int'(val[roct_pkg::SIZE_BITS-1:0]);
            end
        endfunction

        function void note_action(obstacle_txn_t t);
            collision_result_t r;
            int px;
            int py;
            int idx;
            int i;
            r.hit    = 1'b0;
            r.status = roct_pkg::STS_OK;
            px  = int'(t.x);
            py  = int'(t.y);
            idx = int'(t.index);
            case (t.action)
                roct_pkg::ACT_APPEND: begin
                    if (n_rects >= roct_pkg::MAX_RECTS) begin
                        r.status = roct_pkg::STS_FULL;
                    end else begin
                        rx[n_rects] = px;
                        ry[n_rects] = py;
                        rw[n_rects] = int'(t.w);
                        rh[n_rects] = int'(t.h);
                        n_rects++;
                    end
                end
                roct_pkg::ACT_REMOVE: begin
                    if (idx >= n_rects) begin
                        r.status = roct_pkg::STS_RANGE;
                    end else begin
                        for (i = idx; i + 1 < n_rects; i++) begin
                            rx[i] = rx[i+1];
                            ry[i] = ry[i+1];
                            rw[i] = rw[i+1];
                            rh[i] = rh[i+1];
                        end
                        n_rects--;
                    end
                end
                roct_pkg::ACT_MOVE: begin
                    if (idx >= n_rects) begin
                        r.status = roct_pkg::STS_RANGE;
                    end else begin
                        rx[idx] = px;
                        ry[idx] = py;
                    end
                end
                roct_pkg::ACT_BOX: begin
                    for (i = 0; i < n_rects; i++) begin
                        if (px <= rx[i] + rw[i] && rx[i] <= px + box_w &&
                            py <= ry[i] + rh[i] && ry[i] <= py + box_h) begin
                            r.hit = 1'b1;
                        end
                    end
                end
                roct_pkg::ACT_POINT: begin
                    for (i = 0; i < n_rects; i++) begin
                        if (px >= rx[i] && px <= rx[i] + rw[i] &&
                            py >= ry[i] && py <= ry[i] + rh[i]) begin
                            r.hit = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            r.count = n_rects[roct_pkg::CNT_BITS-1:0];
            expected_q = {expected_q, r};
        endfunction

        function void check_result(logic hit, logic [1:0] status,
                                   logic [roct_pkg::CNT_BITS-1:0] cnt);
            collision_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: hit %0d status %0d count %0d",
                             hit, status, cnt);
                return;
            end
            e = expected_q.pop_front();
            if (hit !== e.hit || status !== e.status || cnt !== e.count) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result %0d hit/status/count: exp %0d/%0d/%0d got %0d/%0d/%0d",
                             checked, e.hit, e.status, e.count, hit, status, cnt);
            end
            checked++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int count();
            return n_rects;
        endfunction
    endclass

    logic                                   aclk;
    logic                                   aresetn;
    logic                                   s_valid;
    logic                                   s_ready;
    logic [2:0]                             s_action;
    logic [roct_pkg::IDX_BITS-1:0]          s_entry_index;
    logic signed [roct_pkg::COORD_BITS-1:0] s_pos_x;
    logic signed [roct_pkg::COORD_BITS-1:0] s_pos_y;
    logic [roct_pkg::SIZE_BITS-1:0]         s_rect_w;
    logic [roct_pkg::SIZE_BITS-1:0]         s_rect_h;
    logic                                   m_valid;
    logic                                   m_ready;
    logic                                   m_hit;
    logic [1:0]                             m_status;
    logic [roct_pkg::CNT_BITS-1:0]          m_entry_count;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [roct_pkg::CFG_ADDR_BITS-1:0]     paddr;
    logic [roct_pkg::APB_DATA_W-1:0]        pwdata;
    logic [roct_pkg::APB_DATA_W-1:0]        prdata;
    logic                                   pready;

    collision_scoreboard tracker = new();
    bit send_calm;
    int send_span;

    rect_obstacle_collision_table DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_entry_index (s_entry_index),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_rect_w      (s_rect_w),
        .s_rect_h      (s_rect_h),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(20_000_000);
        $display("rect_obstacle_collision_table test failed");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int draw_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [roct_pkg::COORD_BITS-1:0] rand_coord();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            v = $urandom();
            return v[roct_pkg::COORD_BITS-1:0];
        end
        if (r < 12)
            return ($urandom_range(0, 1) != 0) ? {1'b0, {(roct_pkg::COORD_BITS-1){1'b1}}}
                                               : {1'b1, {(roct_pkg::COORD_BITS-1){1'b0}}};
        v = $urandom_range(0, 4000) - 2000;
        return v[roct_pkg::COORD_BITS-1:0];
    endfunction

    function automatic logic [roct_pkg::SIZE_BITS-1:0] rand_size();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            v = $urandom();
            return v[roct_pkg::SIZE_BITS-1:0];
        end
        if (r < 12)
            return ($urandom_range(0, 1) != 0) ? {roct_pkg::SIZE_BITS{1'b1}} : '0;
        v = $urandom_range(0, 600);
        return v[roct_pkg::SIZE_BITS-1:0];
    endfunction

    function automatic obstacle_txn_t mk_action(int a, int idx, int x, int y,
                                                int w, int h);
        obstacle_txn_t t;
        t.action = a[2:0];
        t.index  = idx[roct_pkg::IDX_BITS-1:0];
        t.x      = x[roct_pkg::COORD_BITS-1:0];
        t.y      = y[roct_pkg::COORD_BITS-1:0];
        t.w      = w[roct_pkg::SIZE_BITS-1:0];
        t.h      = h[roct_pkg::SIZE_BITS-1:0];
        return t;
    endfunction

    // bias: 0 grows the table, 1 shrinks it, 2 keeps it steady
    function automatic obstacle_txn_t rand_action(int bias, int n_now);
        obstacle_txn_t t;
        int ap;
        int rm;
        int r;
        int ix;
        ap = (bias == 0) ? 55 : (bias == 1) ? 12 : 22;
        rm = (bias == 1) ? 45 : (bias == 0) ? 8 : 18;
        r  = $urandom_range(0, 99);
        if (r < ap)
            t.action = roct_pkg::ACT_APPEND;
        else if (r < ap + rm)
            t.action = roct_pkg::ACT_REMOVE;
        else if (r < ap + rm + 10)
            t.action = roct_pkg::ACT_MOVE;
        else if (r < 97 - (97 - ap - rm - 10) / 2)
            t.action = roct_pkg::ACT_BOX;
        else if (r < 97)
            t.action = roct_pkg::ACT_POINT;
        else
            t.action = 3'($urandom_range(int'(roct_pkg::ACT_POINT) + 1, ACTION_SPACE - 1));
        if (n_now == 0 || $urandom_range(0, 9) == 0)
            ix = $urandom_range(0, roct_pkg::MAX_RECTS - 1);
        else
            ix = $urandom_range(0, n_now - 1);
        t.index = ix[roct_pkg::IDX_BITS-1:0];
        t.x = rand_coord();
        t.y = rand_coord();
        t.w = rand_size();
        t.h = rand_size();
        return t;
    endfunction

    task automatic send_action(obstacle_txn_t t);
        int gap;
        if (send_span == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
            send_span = $urandom_range(30, 200);
        end
        send_span--;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= t.action;
        s_entry_index <= t.index;
        s_pos_x       <= t.x;
        s_pos_y       <= t.y;
        s_rect_w      <= t.w;
        s_rect_h      <= t.h;
        do @(posedge aclk); while (!s_ready);
        tracker.note_action(t);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [roct_pkg::CFG_IDX_BITS-1:0] reg_idx,
                             logic [roct_pkg::SIZE_BITS-1:0] val);
        logic [roct_pkg::APB_DATA_W-1:0] word;
        word = $urandom();
        word[roct_pkg::SIZE_BITS-1:0] = val;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_player(reg_idx, word);
    endtask

    initial begin
        int stall;
        int span;
        bit calm;
        stall = 0;
        span  = 0;
        calm  = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (span == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                span = $urandom_range(50, 400);
            end
            span--;
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = draw_gap(calm);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_hit, m_status, m_entry_count);
    end

    initial begin
        int p;
        int k;
        int a;
        int bias;
        int v;
        logic [roct_pkg::SIZE_BITS-1:0] cw;
        logic [roct_pkg::SIZE_BITS-1:0] ch;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_action      <= '0;
        s_entry_index <= '0;
        s_pos_x       <= '0;
        s_pos_y       <= '0;
        s_rect_w      <= '0;
        s_rect_h      <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        send_calm     = 1'b0;
        send_span     = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, out-of-range index, spare codes
        send_action(mk_action(roct_pkg::ACT_BOX, 0, 0, 0, 0, 0));
        send_action(mk_action(roct_pkg::ACT_POINT, 0, 0, 0, 0, 0));
        send_action(mk_action(roct_pkg::ACT_REMOVE, 0, 0, 0, 0, 0));
        send_action(mk_action(roct_pkg::ACT_MOVE, roct_pkg::MAX_RECTS - 1, 5, 5, 0, 0));
        for (a = int'(roct_pkg::ACT_POINT) + 1; a < ACTION_SPACE; a++)
            send_action(mk_action(a, 0, 1, 1, 1, 1));
        // extreme corners and sizes, edge sums past the coordinate range
        send_action(mk_action(roct_pkg::ACT_APPEND, 0, -32768, -32768, 4095, 4095));
        send_action(mk_action(roct_pkg::ACT_APPEND, 0, 32767, 32767, 4095, 4095));
        send_action(mk_action(roct_pkg::ACT_APPEND, 0, 0, 0, 0, 0));
        send_action(mk_action(roct_pkg::ACT_POINT, 0, -28673, -28673, 0, 0));
        send_action(mk_action(roct_pkg::ACT_POINT, 0, -28672, -28673, 0, 0));
        send_action(mk_action(roct_pkg::ACT_POINT, 0, 32767, 32767, 0, 0));
        send_action(mk_action(roct_pkg::ACT_POINT, 0, 0, 0, 0, 0));
        send_action(mk_action(roct_pkg::ACT_BOX, 0, 0, 0, 0, 0));
        send_action(mk_action(roct_pkg::ACT_BOX, 0, -1, -1, 0, 0));
        send_action(mk_action(roct_pkg::ACT_MOVE, 2, 100, -100, 0, 0));
        send_action(mk_action(roct_pkg::ACT_POINT, 0, 100, -100, 0, 0));
        send_action(mk_action(roct_pkg::ACT_MOVE, 3, 7, 7, 0, 0));
        send_action(mk_action(roct_pkg::ACT_REMOVE, 0, 0, 0, 0, 0));
        send_action(mk_action(roct_pkg::ACT_POINT, 0, -32768, -32768, 0, 0));
        send_action(mk_action(roct_pkg::ACT_REMOVE, 1, 0, 0, 0, 0));
        send_action(mk_action(roct_pkg::ACT_REMOVE, 1, 0, 0, 0, 0));
        drain();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin cw = '0; ch = '0; end
                1: begin cw = {roct_pkg::SIZE_BITS{1'b1}}; ch = {roct_pkg::SIZE_BITS{1'b1}}; end
                2: begin cw = '0; ch = {roct_pkg::SIZE_BITS{1'b1}}; end
                3: begin cw = {roct_pkg::SIZE_BITS{1'b1}}; ch = '0; end
                default: begin
                    v  = $urandom_range(0, 300);
                    cw = v[roct_pkg::SIZE_BITS-1:0];
                    v  = $urandom_range(0, 300);
                    ch = v[roct_pkg::SIZE_BITS-1:0];
                end
            endcase
            cfg_write(roct_pkg::REG_PLAYER_WIDTH, cw);
            cfg_write(roct_pkg::REG_PLAYER_HEIGHT, ch);
            bias = 0;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 60 == 0)
                    bias = (k == 0) ? 0 : $urandom_range(0, 2);
                send_action(rand_action(bias, tracker.count()));
            end
            drain();
        end

        repeat (100) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("rect_obstacle_collision_table test passed");
        end else begin
            $display("rect_obstacle_collision_table test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/roct_pkg.sv
rtl/roct_ram.sv
rtl/rect_obstacle_collision_table.sv
verif/rect_obstacle_collision_table_tb.sv
